>>> sv/rpn_pkg.sv
// Shared types and codes for the RPN stack calculator.
package rpn_pkg;

    localparam logic [3:0] CMD_PUSH = 4'd0;
    localparam logic [3:0] CMD_ADD  = 4'd1;
    localparam logic [3:0] CMD_SUB  = 4'd2;
    localparam logic [3:0] CMD_MUL  = 4'd3;
    localparam logic [3:0] CMD_DIV  = 4'd4;
    localparam logic [3:0] CMD_MOD  = 4'd5;
    localparam logic [3:0] CMD_POP  = 4'd6;
    localparam logic [3:0] CMD_DUP  = 4'd7;
    localparam logic [3:0] CMD_SWP  = 4'd8;
    localparam logic [3:0] CMD_ROL  = 4'd9;
    localparam logic [3:0] CMD_DUMP = 4'd11;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_FEW  = 3'd1;
    localparam logic [2:0] ERR_DIV0 = 3'd2;
    localparam logic [2:0] ERR_ROT  = 3'd3;
    localparam logic [2:0] ERR_INV  = 3'd4;
    localparam logic [2:0] ERR_OVF  = 3'd5;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] push_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic               entry_valid;
        logic [6:0]         stack_count;
        logic [2:0]         error_code;
        logic               last_result;
    } t_out;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_ABOVE,
        CELL_FROM_BELOW,
        CELL_LOAD
    } t_cell_mode;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

>>> sv/rpn_stack_calculator.sv
// RPN stack calculator top level: command control, cell row and serial ALU.
//
// A command request enters on the input channel (i_in_valid, o_in_ready,
// i_in_data) and its result requests leave on the output channel
// (o_out_valid, i_out_ready, o_out_data). One command is worked on at a time;
// o_in_ready is high only while the controller waits for a new command.
// The stack is a row of cells with the top in the first cell; each cell takes
// a word from a neighbor, so push, pop and arithmetic shift the whole row.
// Push, pop, dup, swap, add, sub and error cases go from idle to the response
// state, except divide or mod by zero, which drops its second operand in a drop state.
// Mul, div and mod run on a bit-serial unit while the controller waits for it.
// Rol n works by adjacent exchanges, one exchange per cycle.
// Dump rotates the whole row once, holding while the receiver stalls, and
// sends one request per entry, bottom first; the row is unchanged afterward.
// Reset clears the depth, the sticky error and the output valid flag; stack
// contents need no clearing. When the receiver stalls, the result waits in
// the output register and the controller holds until it is taken.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ARITH = 6'b000010,
        ST_DROP  = 6'b000100,
        ST_ROL   = 6'b001000,
        ST_DUMP  = 6'b010000,
        ST_RESP  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [DW-1:0]          r_depth, n_depth;
    logic [DW-1:0]          r_cnt, n_cnt;
    logic [2:0]             r_err, n_err;
    t_out                   r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    t_cell_mode             w_mode [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] w_val  [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] w_load;
    logic [VALUE_WIDTH-1:0] w_top, w_sec;
    logic                   w_slot_free;
    logic                   w_want;
    logic                   w_bad_rol;
    t_alu_req               w_alu_req;
    logic                   w_alu_done;
    logic [VALUE_WIDTH-1:0] w_alu_result;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_above, w_below;
            if (g == 0) begin : g_first
                assign w_above = w_val[STACK_DEPTH-1];
            end else begin : g_mid
                assign w_above = w_val[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign w_below = '0;
            end else begin : g_rest
                assign w_below = w_val[g+1];
            end
            rpn_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_mode  (w_mode[g]),
                .i_above (w_above),
                .i_below (w_below),
                .i_load  (w_load),
                .o_value (w_val[g])
            );
        end
    endgenerate

    rpn_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_lhs    (w_sec),
        .i_rhs    (w_top),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    assign w_top       = w_val[0];
    assign w_sec       = w_val[1];
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_want      = (r_cnt != '0) &&
                         (({1'b0, r_cnt} + {1'b0, r_depth}) > (DW + 1)'(STACK_DEPTH));
    assign w_bad_rol   = w_top[VALUE_WIDTH-1] || (w_top < VALUE_WIDTH'(2)) ||
                         (w_top > VALUE_WIDTH'(r_depth - DW'(1)));

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_load      = '0;
        w_alu_req   = '{start: 1'b0, op: ALU_MUL};
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_mode[i] = CELL_HOLD;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RESP;
                    if (i_in_data.command == CMD_DUMP) begin
                        if (r_depth != '0) begin
                            n_state = ST_DUMP;
                            n_cnt   = '0;
                        end
                    end else if (r_err == ERR_NONE) begin
                        case (i_in_data.command)
                            CMD_PUSH: begin
                                if (r_depth >= DW'(STACK_DEPTH)) begin
                                    n_err = ERR_OVF;
                                end else begin
                                    for (int i = 1; i < STACK_DEPTH; i++) begin
                                        w_mode[i] = CELL_FROM_ABOVE;
                                    end
                                    w_mode[0] = CELL_LOAD;
                                    w_load    = VALUE_WIDTH'(i_in_data.push_value);
                                    n_depth   = r_depth + DW'(1);
                                end
                            end
                            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                                if (r_depth == DW'(1)) begin
                                    n_depth = '0;
                                    n_err   = ERR_FEW;
                                end else if (r_depth != '0) begin
                                    if ((i_in_data.command == CMD_DIV ||
                                         i_in_data.command == CMD_MOD) && w_top == '0) begin
                                        for (int i = 0; i < STACK_DEPTH; i++) begin
                                            w_mode[i] = CELL_FROM_BELOW;
                                        end
                                        n_depth = r_depth - DW'(2);
                                        n_err   = ERR_DIV0;
                                        n_state = ST_DROP;
                                    end else if (i_in_data.command == CMD_ADD ||
                                                 i_in_data.command == CMD_SUB) begin
                                        for (int i = 1; i < STACK_DEPTH; i++) begin
                                            w_mode[i] = CELL_FROM_BELOW;
                                        end
                                        w_mode[0] = CELL_LOAD;
                                        w_load    = (i_in_data.command == CMD_ADD) ?
                                                    (w_sec + w_top) : (w_sec - w_top);
                                        n_depth   = r_depth - DW'(1);
                                    end else begin
                                        w_alu_req.start = 1'b1;
                                        if (i_in_data.command == CMD_MUL) begin
                                            w_alu_req.op = ALU_MUL;
                                        end else if (i_in_data.command == CMD_DIV) begin
                                            w_alu_req.op = ALU_DIV;
                                        end else begin
                                            w_alu_req.op = ALU_MOD;
                                        end
                                        n_state = ST_ARITH;
                                    end
                                end
                            end
                            CMD_POP: begin
                                if (r_depth != '0) begin
                                    for (int i = 0; i < STACK_DEPTH; i++) begin
                                        w_mode[i] = CELL_FROM_BELOW;
                                    end
                                    n_depth = r_depth - DW'(1);
                                end
                            end
                            CMD_DUP: begin
                                if (r_depth >= DW'(STACK_DEPTH)) begin
                                    n_err = ERR_OVF;
                                end else if (r_depth != '0) begin
                                    for (int i = 1; i < STACK_DEPTH; i++) begin
                                        w_mode[i] = CELL_FROM_ABOVE;
                                    end
                                    n_depth = r_depth + DW'(1);
                                end
                            end
                            CMD_SWP: begin
                                if (r_depth >= DW'(2)) begin
                                    w_mode[0] = CELL_FROM_BELOW;
                                    w_mode[1] = CELL_FROM_ABOVE;
                                end
                            end
                            CMD_ROL: begin
                                if (r_depth == '0) begin
                                    n_err = ERR_FEW;
                                end else begin
                                    for (int i = 0; i < STACK_DEPTH; i++) begin
                                        w_mode[i] = CELL_FROM_BELOW;
                                    end
                                    n_depth = r_depth - DW'(1);
                                    if (w_bad_rol) begin
                                        n_err = ERR_ROT;
                                    end else begin
                                        n_cnt   = DW'(w_top) - DW'(1);
                                        n_state = ST_ROL;
                                    end
                                end
                            end
                            default: begin
                                n_err = ERR_INV;
                            end
                        endcase
                    end
                end
            end
            ST_ARITH: begin
                if (w_alu_done) begin
                    for (int i = 1; i < STACK_DEPTH; i++) begin
                        w_mode[i] = CELL_FROM_BELOW;
                    end
                    w_mode[0] = CELL_LOAD;
                    w_load    = w_alu_result;
                    n_depth   = r_depth - DW'(1);
                    n_state   = ST_RESP;
                end
            end
            ST_DROP: begin
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    w_mode[i] = CELL_FROM_BELOW;
                end
                n_state = ST_RESP;
            end
            ST_ROL: begin
                if (r_cnt == '0) begin
                    n_state = ST_RESP;
                end else begin
                    for (int i = 0; i < STACK_DEPTH; i++) begin
                        if (r_cnt == DW'(i)) begin
                            w_mode[i] = CELL_FROM_ABOVE;
                        end
                        if (r_cnt == DW'(i + 1)) begin
                            w_mode[i] = CELL_FROM_BELOW;
                        end
                    end
                    n_cnt = r_cnt - DW'(1);
                end
            end
            ST_DUMP: begin
                if (!w_want || w_slot_free) begin
                    if (w_want) begin
                        n_out_valid       = 1'b1;
                        n_out.out_value   = 32'(w_top);
                        n_out.entry_valid = 1'b1;
                        n_out.stack_count = 7'(r_depth);
                        n_out.error_code  = r_err;
                        n_out.last_result = (r_cnt == DW'(STACK_DEPTH));
                    end
                    if (r_cnt == DW'(STACK_DEPTH)) begin
                        n_state = ST_IDLE;
                    end else begin
                        for (int i = 0; i < STACK_DEPTH; i++) begin
                            w_mode[i] = CELL_FROM_ABOVE;
                        end
                        n_cnt = r_cnt + DW'(1);
                    end
                end
            end
            ST_RESP: begin
                if (w_slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_value   = (r_depth == '0) ? 32'd0 : 32'(w_top);
                    n_out.entry_valid = (r_depth != '0);
                    n_out.stack_count = 7'(r_depth);
                    n_out.error_code  = r_err;
                    n_out.last_result = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_cnt       <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/rpn_cell.sv
// One stack cell: holds a word, loads it, or takes a neighbor's word.
module rpn_cell
    import rpn_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  t_cell_mode             i_mode,
    input  logic [VALUE_WIDTH-1:0] i_above,
    input  logic [VALUE_WIDTH-1:0] i_below,
    input  logic [VALUE_WIDTH-1:0] i_load,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    always_comb begin
        case (i_mode)
            CELL_HOLD:       n_value = r_value;
            CELL_FROM_ABOVE: n_value = i_above;
            CELL_FROM_BELOW: n_value = i_below;
            CELL_LOAD:       n_value = i_load;
            default:         n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> sv/rpn_alu.sv
// Bit-serial multiplier and signed divider shared by mul, div and mod.
module rpn_alu
    import rpn_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_alu_req               i_req,
    input  logic [VALUE_WIDTH-1:0] i_lhs,
    input  logic [VALUE_WIDTH-1:0] i_rhs,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_result
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CW-1:0]          r_cnt, n_cnt;
    t_alu_op                r_op, n_op;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [VALUE_WIDTH-1:0] r_q, n_q;
    logic [VALUE_WIDTH-1:0] r_b, n_b;
    logic                   r_sl, n_sl;
    logic                   r_sr, n_sr;
    logic [VALUE_WIDTH:0]   w_shift;
    logic [VALUE_WIDTH:0]   w_diff;

    function automatic logic [VALUE_WIDTH-1:0] mag(input logic [VALUE_WIDTH-1:0] x);
        mag = x[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - x) : x;
    endfunction

    assign w_shift = {r_acc, r_q[VALUE_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_q    = r_q;
        n_b    = r_b;
        n_sl   = r_sl;
        n_sr   = r_sr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(VALUE_WIDTH);
            n_op   = i_req.op;
            n_acc  = '0;
            n_sl   = i_lhs[VALUE_WIDTH-1];
            n_sr   = i_rhs[VALUE_WIDTH-1];
            if (i_req.op == ALU_MUL) begin
                n_q = i_rhs;
                n_b = i_lhs;
            end else begin
                n_q = mag(i_lhs);
                n_b = mag(i_rhs);
            end
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
                if (r_op == ALU_MUL) begin
                    if (r_q[0]) begin
                        n_acc = r_acc + r_b;
                    end
                    n_b = {r_b[VALUE_WIDTH-2:0], 1'b0};
                    n_q = {1'b0, r_q[VALUE_WIDTH-1:1]};
                end else if (!w_diff[VALUE_WIDTH]) begin
                    n_acc = w_diff[VALUE_WIDTH-1:0];
                    n_q   = {r_q[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    n_acc = w_shift[VALUE_WIDTH-1:0];
                    n_q   = {r_q[VALUE_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        case (r_op)
            ALU_MUL: o_result = r_acc;
            ALU_DIV: o_result = (r_sl ^ r_sr) ? (VALUE_WIDTH'(0) - r_q) : r_q;
            ALU_MOD: o_result = r_sl ? (VALUE_WIDTH'(0) - r_acc) : r_acc;
            default: o_result = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op  <= n_op;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_b   <= n_b;
        r_sl  <= n_sl;
        r_sr  <= n_sr;
    end

    assign o_done = r_done;

endmodule

>>> sv/rpn_checker.sv
// Port checker for the RPN stack calculator and its bind statement.
module rpn_checker
    import rpn_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("Output request changed before it was taken.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.entry_valid |->
        i_out_data.out_value == 32'd0 && i_out_data.stack_count == 7'd0 &&
        i_out_data.last_result)
        else $error("Empty-stack result carries data.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.stack_count <= 7'd64 && i_out_data.error_code <= 3'd5)
        else $error("Result fields out of range.");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("A second command was accepted before the first finished.");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
